// ----- sv/hsms_pkg.sv -----
// Shared types and constants for the humidity sensor measurement sequencer.
// No dependencies; used by every module of the block.
package hsms_pkg;

	// Default countdown width
	localparam int TimerBitsDef = 16;

	// Command codes carried by an input request
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_REPLY = 2'd2;

	// Bus transaction codes
	localparam logic [1:0] BUS_NONE  = 2'd0;
	localparam logic [1:0] BUS_PROBE = 2'd1;
	localparam logic [1:0] BUS_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_DEV_ADDR   = 2'd0;
	localparam logic [1:0] REG_PWR_SWITCH = 2'd1;
	localparam logic [1:0] REG_PWRUP_DLY  = 2'd2;
	localparam logic [1:0] REG_CONV_DLY   = 2'd3;

	// Configuration reset values
	localparam logic [6:0]  DevAddrRst   = 7'd39;
	localparam logic [15:0] PwrUpDlyRst  = 16'd75;
	localparam logic [15:0] ConvDlyRst   = 16'd45;

	// Status and invalid result codes
	localparam logic [2:0]  STATUS_TIMEOUT = 3'd4;
	localparam logic [2:0]  STATUS_UNINIT  = 3'd5;
	localparam logic [15:0] HumInvalid     = 16'hFFFF;
	localparam logic [15:0] TempInvalid    = 16'h7FFF;

	// Conversion scale factors and offset
	localparam logic [13:0] HumScale   = 14'd10000;
	localparam logic [14:0] TempScale  = 15'd16500;
	localparam logic [15:0] TempOffset = 16'd4000;
	// ceil(2^43 / 16382): exact floor division by 16382 for products below 2^29
	localparam int          RecipShift = 43;
	localparam logic [29:0] RecipMul   = 30'd536936457;

	typedef enum logic [2:0] {
		PH_OFF        = 3'd0,
		PH_POWERING   = 3'd1,
		PH_PROBING    = 3'd2,
		PH_CONVERTING = 3'd3,
		PH_READING    = 3'd4,
		PH_FINISHED   = 3'd5
	} phase_t;

	// Configuration register file contents
	typedef struct packed {
		logic [6:0]  dev_addr;
		logic        pwr_switch;
		logic [15:0] pwrup_dly;
		logic [15:0] conv_dly;
	} cfg_t;

	// Request fields held in the input register
	typedef struct packed {
		logic [1:0]  cmd;
		logic        failed;
		logic [1:0]  status;
		logic [13:0] raw_hum;
		logic [13:0] raw_temp;
	} item_s1_t;

	// Request after the scale multiply
	typedef struct packed {
		logic [1:0]  cmd;
		logic        failed;
		logic [1:0]  status;
		logic [27:0] prod_hum;
		logic [28:0] prod_temp;
	} item_s2_t;

	// Converted readings
	typedef struct packed {
		logic [15:0] hum;
		logic [15:0] temp;
	} conv_t;

endpackage

// ----- sv/hsms_cfg.sv -----
// Configuration register file of the measurement sequencer.
// Depends on hsms_pkg for register indexes, reset values and cfg_t.
module hsms_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_wdata,
	output hsms_pkg::cfg_t   cfg
);

	hsms_pkg::cfg_t cfg_q;

	// Register writes, one index per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr   <= hsms_pkg::DevAddrRst;
			cfg_q.pwr_switch <= 1'b0;
			cfg_q.pwrup_dly  <= hsms_pkg::PwrUpDlyRst;
			cfg_q.conv_dly   <= hsms_pkg::ConvDlyRst;
		end else if (cfg_write) begin
			case (cfg_index)
				hsms_pkg::REG_DEV_ADDR:   cfg_q.dev_addr   <= cfg_wdata[6:0];
				hsms_pkg::REG_PWR_SWITCH: cfg_q.pwr_switch <= cfg_wdata[0];
				hsms_pkg::REG_PWRUP_DLY:  cfg_q.pwrup_dly  <= cfg_wdata;
				hsms_pkg::REG_CONV_DLY:   cfg_q.conv_dly   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/hsms_conv.sv -----
// Raw-to-centi conversion: scale multiply into stage 2, then an exact
// reciprocal multiply for the divide by 16382. Depends on hsms_pkg.
module hsms_conv (
	input  logic                clk,
	input  logic                en_s2,
	input  hsms_pkg::item_s1_t  item_s1,
	output hsms_pkg::item_s2_t  item_s2,
	output hsms_pkg::conv_t     conv
);

	hsms_pkg::item_s2_t item_s2_q;
	logic [57:0] quot_hum_full;
	logic [58:0] quot_temp_full;
	logic [15:0] temp_raw_centi;

	// Stage 2: scale the raw readings
	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2_q.cmd       <= item_s1.cmd;
			item_s2_q.failed    <= item_s1.failed;
			item_s2_q.status    <= item_s1.status;
			item_s2_q.prod_hum  <= 28'(item_s1.raw_hum) * 28'(hsms_pkg::HumScale);
			item_s2_q.prod_temp <= 29'(item_s1.raw_temp) * 29'(hsms_pkg::TempScale);
		end
	end

	// Floor divide by 16382 via reciprocal multiply
	always_comb begin
		quot_hum_full  = 58'(item_s2_q.prod_hum)  * 58'(hsms_pkg::RecipMul);
		quot_temp_full = 59'(item_s2_q.prod_temp) * 59'(hsms_pkg::RecipMul);
		temp_raw_centi = quot_temp_full[hsms_pkg::RecipShift +: 16];
		conv.hum  = quot_hum_full[hsms_pkg::RecipShift +: 15] == 15'd0 ? 16'd0 :
		            16'(quot_hum_full[hsms_pkg::RecipShift +: 15]);
		conv.temp = temp_raw_centi - hsms_pkg::TempOffset;
	end

	assign item_s2 = item_s2_q;

endmodule

// ----- sv/hsms_seq.sv -----
// Measurement sequence state and the result register.
// Depends on hsms_pkg for phase_t, command and bus codes.
module hsms_seq #(
	parameter int TIMER_BITS = hsms_pkg::TimerBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  hsms_pkg::item_s2_t  item_s2,
	input  hsms_pkg::conv_t     conv,
	input  hsms_pkg::cfg_t      cfg,
	output logic                power_on,
	output logic [1:0]          bus_request,
	output logic [6:0]          bus_target,
	output logic                measurement_done,
	output logic [2:0]          sensor_status,
	output logic [15:0]         humidity_centi,
	output logic signed [15:0]  temperature_centi
);

	localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

	hsms_pkg::phase_t phase_q, phase_d;
	logic [TIMER_BITS-1:0] delay_q, delay_d, dec_delay;
	logic [TIMER_BITS-1:0] pwrup_load, conv_load;
	logic        power_q, power_d;
	logic [15:0] hum_q, hum_d, temp_q, temp_d;
	logic [2:0]  status_q, status_d;
	logic [1:0]  req_d;

	// Saturating load of a 16-bit delay into the countdown
	always_comb begin
		pwrup_load = (32'(cfg.pwrup_dly) > 32'(TimerMax)) ? TimerMax
		             : TIMER_BITS'(cfg.pwrup_dly);
		conv_load  = (32'(cfg.conv_dly) > 32'(TimerMax)) ? TimerMax
		             : TIMER_BITS'(cfg.conv_dly);
	end

	// Next state for the request in stage 2
	always_comb begin
		phase_d   = phase_q;
		delay_d   = delay_q;
		power_d   = power_q;
		hum_d     = hum_q;
		temp_d    = temp_q;
		status_d  = status_q;
		req_d     = hsms_pkg::BUS_NONE;
		dec_delay = (delay_q != '0) ? delay_q - 1'b1 : delay_q;
		case (item_s2.cmd)
			hsms_pkg::CMD_START: begin
				if (cfg.pwr_switch) begin
					power_d = 1'b1;
					delay_d = pwrup_load;
				end
				phase_d = hsms_pkg::PH_POWERING;
			end
			hsms_pkg::CMD_TICK: begin
				delay_d = dec_delay;
				if (dec_delay == '0) begin
					if (phase_q == hsms_pkg::PH_POWERING) begin
						req_d   = hsms_pkg::BUS_PROBE;
						phase_d = hsms_pkg::PH_PROBING;
					end else if (phase_q == hsms_pkg::PH_CONVERTING) begin
						req_d   = hsms_pkg::BUS_READ;
						phase_d = hsms_pkg::PH_READING;
					end
				end
			end
			hsms_pkg::CMD_REPLY: begin
				if (phase_q == hsms_pkg::PH_PROBING ||
				    phase_q == hsms_pkg::PH_READING) begin
					if (item_s2.failed) begin
						power_d  = 1'b0;
						phase_d  = hsms_pkg::PH_FINISHED;
						hum_d    = hsms_pkg::HumInvalid;
						temp_d   = hsms_pkg::TempInvalid;
						status_d = hsms_pkg::STATUS_TIMEOUT;
					end else if (phase_q == hsms_pkg::PH_PROBING) begin
						delay_d = conv_load;
						phase_d = hsms_pkg::PH_CONVERTING;
					end else begin
						hum_d    = conv.hum;
						temp_d   = conv.temp;
						status_d = {1'b0, item_s2.status};
						power_d  = 1'b0;
						phase_d  = hsms_pkg::PH_FINISHED;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hsms_pkg::PH_OFF;
			delay_q  <= TIMER_BITS'(hsms_pkg::PwrUpDlyRst);
			power_q  <= 1'b0;
			hum_q    <= hsms_pkg::HumInvalid;
			temp_q   <= hsms_pkg::TempInvalid;
			status_q <= hsms_pkg::STATUS_UNINIT;
		end else if (adv) begin
			phase_q  <= phase_d;
			delay_q  <= delay_d;
			power_q  <= power_d;
			hum_q    <= hum_d;
			temp_q   <= temp_d;
			status_q <= status_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			power_on          <= power_d;
			bus_request       <= req_d;
			bus_target        <= (req_d != hsms_pkg::BUS_NONE) ? cfg.dev_addr : 7'd0;
			measurement_done  <= (phase_d == hsms_pkg::PH_FINISHED);
			sensor_status     <= status_d;
			humidity_centi    <= hum_d;
			temperature_centi <= temp_d;
		end
	end

endmodule

// ----- sv/humidity_sensor_measure_sequencer_core.sv -----
// Top level of the humidity sensor measurement sequencer.
// Depends on hsms_pkg, hsms_cfg, hsms_conv and hsms_seq.
// Usage:
//   Input channel (in_valid/in_ready) carries one request per cycle while
//   ready: a start command, a millisecond tick, or a four-byte bus reply.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   request: power switch level, the bus transaction to issue now, the done
//   flag and the last humidity, temperature and status.
//   Configuration port (cfg_write/cfg_index/cfg_wdata) writes one register
//   per cycle, with no handshake; write only while the block is idle.
// Path from request to result: input register, scale multiply stage,
//   reciprocal divide and sequence update into the result register.
// Throughput: one request per cycle; the pipeline advances whenever the
//   result register is empty or being taken.
// Reset: phase off, power off, results invalid, status uninitialized, the
//   countdown loaded with the default power-up delay; configuration returns
//   to its defaults.
// Stall: when out_ready is low, stages fill up and in_ready drops once the
//   result register and both pipeline stages hold requests.
module humidity_sensor_measure_sequencer_core #(
	parameter int TIMER_BITS = hsms_pkg::TimerBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic               bus_timed_out,
	input  logic [7:0]         reply_byte0,
	input  logic [7:0]         reply_byte1,
	input  logic [7:0]         reply_byte2,
	input  logic [7:0]         reply_byte3,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               power_on,
	output logic [1:0]         bus_request,
	output logic [6:0]         bus_target,
	output logic               measurement_done,
	output logic [2:0]         sensor_status,
	output logic [15:0]        humidity_centi,
	output logic signed [15:0] temperature_centi
);

	hsms_pkg::cfg_t     cfg;
	hsms_pkg::item_s1_t item_s1;
	hsms_pkg::item_s2_t item_s2;
	hsms_pkg::conv_t    conv;
	logic valid_s1, valid_s2, out_valid_q;
	logic adv_out, adv_s2, take_in;

	// Pipeline flow control
	always_comb begin
		adv_out  = valid_s2 && (!out_valid_q || out_ready);
		adv_s2   = valid_s1 && (!valid_s2 || adv_out);
		in_ready = !valid_s1 || adv_s2;
		take_in  = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!valid_s2 || adv_out)
				valid_s2 <= adv_s2;
			if (!out_valid_q || out_ready)
				out_valid_q <= adv_out;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.cmd      <= cmd;
			item_s1.failed   <= bus_timed_out;
			item_s1.status   <= reply_byte0[7:6];
			item_s1.raw_hum  <= {reply_byte0[5:0], reply_byte1};
			item_s1.raw_temp <= {reply_byte2, reply_byte3[7:2]};
		end
	end

	assign out_valid = out_valid_q;

	hsms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hsms_conv u_conv (
		.clk     (clk),
		.en_s2   (adv_s2),
		.item_s1 (item_s1),
		.item_s2 (item_s2),
		.conv    (conv)
	);

	hsms_seq #(
		.TIMER_BITS (TIMER_BITS)
	) u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv_out),
		.item_s2           (item_s2),
		.conv              (conv),
		.cfg               (cfg),
		.power_on          (power_on),
		.bus_request       (bus_request),
		.bus_target        (bus_target),
		.measurement_done  (measurement_done),
		.sensor_status     (sensor_status),
		.humidity_centi    (humidity_centi),
		.temperature_centi (temperature_centi)
	);

endmodule
